@@ rtl/scs_pkg.sv @@
// ----------------------------------------------------------------------------
// scs_pkg: shared types and codes of the 16-bit processor step
// Request and result payloads, instruction opcodes and field positions.
// ----------------------------------------------------------------------------
package scs_pkg;

  localparam int REG_COUNT = 16;

  // Instruction fields: opcode [15:12], rA [11:8], rB [7:4], rY [3:0]
  localparam int LINK_BIT = 7;   // push return address / pop into pc
  localparam int SIGN_BIT = 15;

  // Condition bits of rY for the conditional jump, highest priority first
  localparam int COND_GT = 3;
  localparam int COND_LT = 2;
  localparam int COND_NZ = 1;
  localparam int COND_Z  = 0;

  localparam logic [3:0] OP_MOV  = 4'h0;
  localparam logic [3:0] OP_LDI  = 4'h1;
  localparam logic [3:0] OP_ST   = 4'h2;
  localparam logic [3:0] OP_LD   = 4'h3;
  localparam logic [3:0] OP_OR   = 4'h4;
  localparam logic [3:0] OP_NOT  = 4'h5;
  localparam logic [3:0] OP_AND  = 4'h6;
  localparam logic [3:0] OP_XOR  = 4'h7;
  localparam logic [3:0] OP_ADD  = 4'h8;
  localparam logic [3:0] OP_SUB  = 4'h9;
  localparam logic [3:0] OP_LNOT = 4'hA;
  localparam logic [3:0] OP_SHR  = 4'hB;
  localparam logic [3:0] OP_PUSH = 4'hC;
  localparam logic [3:0] OP_POP  = 4'hD;
  localparam logic [3:0] OP_JMP  = 4'hE;
  localparam logic [3:0] OP_JC   = 4'hF;

  typedef struct packed {
    logic        operation;
    logic [15:0] load_address;
    logic [15:0] load_word;
  } item_t;

  typedef struct packed {
    logic [15:0] pc_after;
    logic        reg_written;
    logic [3:0]  reg_index;
    logic [15:0] reg_value;
    logic        data_written;
    logic [15:0] data_address;
    logic [15:0] data_value;
    logic [15:0] stack_pointer_after;
    logic        jump_taken;
  } result_t;

endpackage

@@ rtl/scs_ram.sv @@
// ----------------------------------------------------------------------------
// scs_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module scs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/scs_wrap.sv @@
// ----------------------------------------------------------------------------
// scs_wrap: reduce a 16-bit address modulo a constant word count
// Two-stage pipeline: reciprocal multiply for the quotient, then multiply
// back, subtract and correct once.
// ----------------------------------------------------------------------------
module scs_wrap #(
  parameter int MODULUS = 65536
) (
  input  logic                       clk,
  input  logic [15:0]                x,
  output logic [$clog2(MODULUS)-1:0] r
);

  localparam int          RW    = $clog2(MODULUS);
  localparam logic [32:0] SCALE = 33'h1_0000_0000;
  localparam logic [32:0] RECIP = SCALE / 33'(MODULUS);
  localparam logic [16:0] MOD17 = 17'(MODULUS);

  logic [48:0] prod;
  logic [15:0] q;
  logic [15:0] xs;
  logic [32:0] qn;
  logic [16:0] rem;
  logic [16:0] rem_fix;

  // quotient estimate is exact or one short
  assign prod = 49'(x) * 49'(RECIP);

  always_ff @(posedge clk) begin
    q  <= prod[47:32];
    xs <= x;
  end

  assign qn      = 33'(q) * 33'(MOD17);
  assign rem     = {1'b0, xs} - qn[16:0];
  assign rem_fix = (rem >= MOD17) ? rem - MOD17 : rem;

  always_ff @(posedge clk) begin
    r <= rem_fix[RW-1:0];
  end

endmodule

@@ rtl/sixteen_bit_cpu_step.sv @@
// Sequence: a program write steps through S_PW1, S_PW2 and S_LOAD; an ALU,
// move, jump, push or pop instruction through S_PW1, S_PW2, S_DEC, S_OPR and
// S_WB; a store adds S_DW1 and S_DW2 before S_WB, a load S_DRD as well. A new
// request is taken only back in idle, after the chain of synchronous reads
// (address wrap, fetch, operand read). Reset: pc, sp and control clear at
// once; a clearing pass then zeroes all memories.
// ----------------------------------------------------------------------------
// sixteen_bit_cpu_step: 16-bit processor executing one instruction per request
// Program, data and stack memories plus a duplicated register file are
// synchronous RAMs; a sequencer reads, computes and writes back.
// ----------------------------------------------------------------------------
module sixteen_bit_cpu_step #(
  parameter int PROGRAM_WORDS = 65536,
  parameter int DATA_WORDS    = 65536,
  parameter int STACK_WORDS   = 65536
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  scs_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output scs_pkg::result_t result
);

  import scs_pkg::*;

  localparam int PAW = $clog2(PROGRAM_WORDS);
  localparam int DAW = $clog2(DATA_WORDS);
  localparam int SAW = $clog2(STACK_WORDS);
  localparam int RAW = $clog2(REG_COUNT);
  localparam int PD_MAX    = (PROGRAM_WORDS > DATA_WORDS) ? PROGRAM_WORDS : DATA_WORDS;
  localparam int MAX_WORDS = (PD_MAX > STACK_WORDS) ? PD_MAX : STACK_WORDS;
  localparam int CW        = $clog2(MAX_WORDS);

  localparam logic [PAW-1:0] P_LAST   = PAW'(PROGRAM_WORDS - 1);
  localparam logic [SAW-1:0] S_LAST   = SAW'(STACK_WORDS - 1);
  localparam logic [CW-1:0]  CLR_LAST = CW'(MAX_WORDS - 1);
  localparam logic [CW-1:0]  CLR_P    = CW'(PROGRAM_WORDS - 1);
  localparam logic [CW-1:0]  CLR_D    = CW'(DATA_WORDS - 1);
  localparam logic [CW-1:0]  CLR_S    = CW'(STACK_WORDS - 1);

  // Sequencer states
  localparam logic [3:0] S_CLEAR = 4'd0;   // zero all memories after reset
  localparam logic [3:0] S_IDLE  = 4'd1;   // wait for a request
  localparam logic [3:0] S_PW1   = 4'd2;   // program address wrap, stage 1
  localparam logic [3:0] S_PW2   = 4'd3;   // wrapped address ready, fetch
  localparam logic [3:0] S_LOAD  = 4'd4;   // commit a program write
  localparam logic [3:0] S_DEC   = 4'd5;   // decode, read registers/imm/stack
  localparam logic [3:0] S_OPR   = 4'd6;   // operands ready
  localparam logic [3:0] S_DW1   = 4'd7;   // data address wrap, stage 1
  localparam logic [3:0] S_DW2   = 4'd8;   // wrapped data address ready
  localparam logic [3:0] S_DRD   = 4'd9;   // data memory read
  localparam logic [3:0] S_WB    = 4'd10;  // compute and write back

  logic [3:0]     state;
  logic [CW-1:0]  clr_addr;
  logic [15:0]    pc;
  logic [SAW-1:0] sp;
  logic           is_load;
  logic [15:0]    lword;
  logic [PAW-1:0] paddr;
  logic [15:0]    instr;
  logic [15:0]    va;
  logic [15:0]    vb;
  logic [15:0]    imm;
  logic [15:0]    entry;
  logic [DAW-1:0] daddr;

  logic accept;
  logic slot_free;
  logic commit;
  logic clearing;

  // Address wrap units
  logic [15:0]    p_wrap_x;
  logic [PAW-1:0] p_wrap_r;
  logic [15:0]    d_wrap_x;
  logic [DAW-1:0] d_wrap_r;

  // RAM ports
  logic           prog_we;
  logic [PAW-1:0] prog_waddr;
  logic [15:0]    prog_wdata;
  logic [PAW-1:0] prog_raddr;
  logic [15:0]    prog_rdata;
  logic           dat_we;
  logic [DAW-1:0] dat_waddr;
  logic [15:0]    dat_wdata;
  logic [15:0]    dat_rdata;
  logic           stk_we;
  logic [SAW-1:0] stk_waddr;
  logic [15:0]    stk_wdata;
  logic [15:0]    stk_rdata;
  logic           rf_we;
  logic [RAW-1:0] rf_waddr;
  logic [15:0]    rf_wdata;
  logic [15:0]    rfa_rdata;
  logic [15:0]    rfb_rdata;

  // Decoded instruction
  logic [3:0] op;
  logic [3:0] ry;
  logic       link;

  logic [PAW-1:0] paddr_inc;
  logic [SAW-1:0] sp_inc;
  logic [SAW-1:0] sp_dec;
  logic [15:0]    pc_plus1;
  logic [15:0]    pc_plus2;

  // Write-back results
  logic [15:0]    res;
  logic           reg_wr;
  logic           jumped;
  logic           take;
  logic [15:0]    pc_next;
  logic [SAW-1:0] sp_next;
  logic           push_wr;
  logic           pop_wr;
  result_t        wb_result;
  result_t        load_result;

  // --------------------------------------------------------------------------
  // Handshake: accept only in idle; a finished result may still wait in the
  // output register while the next request is taken and worked on.
  // --------------------------------------------------------------------------
  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign slot_free  = !result_valid || result_ready;
  assign clearing   = (state == S_CLEAR);
  assign commit     = slot_free && (state == S_WB);

  assign op   = instr[15:12];
  assign ry   = instr[3:0];
  assign link = instr[LINK_BIT];

  assign paddr_inc = (paddr == P_LAST) ? '0 : paddr + 1'b1;
  assign sp_inc    = (sp == S_LAST) ? '0 : sp + 1'b1;
  assign sp_dec    = (sp == '0) ? S_LAST : sp - 1'b1;
  assign pc_plus1  = pc + 16'd1;
  assign pc_plus2  = pc + 16'd2;

  // --------------------------------------------------------------------------
  // Address reduction: program side wraps pc or the write address, data side
  // wraps rB for a store and rA for a load.
  // --------------------------------------------------------------------------
  assign p_wrap_x = item.operation ? item.load_address : pc;
  assign d_wrap_x = (op == OP_ST) ? rfb_rdata : rfa_rdata;

  scs_wrap #(.MODULUS(PROGRAM_WORDS)) u_pwrap (
    .clk (clk),
    .x   (p_wrap_x),
    .r   (p_wrap_r)
  );

  scs_wrap #(.MODULUS(DATA_WORDS)) u_dwrap (
    .clk (clk),
    .x   (d_wrap_x),
    .r   (d_wrap_r)
  );

  // --------------------------------------------------------------------------
  // Memories. During the clearing pass every memory is written with zero at
  // the sweep address while it is inside that memory's depth.
  // --------------------------------------------------------------------------
  assign prog_we    = (clearing && (clr_addr <= CLR_P)) || (state == S_LOAD && slot_free);
  assign prog_waddr = clearing ? clr_addr[PAW-1:0] : paddr;
  assign prog_wdata = clearing ? '0 : lword;
  // fetch at the wrapped pc, then the immediate word right behind it
  assign prog_raddr = (state == S_DEC) ? paddr_inc : p_wrap_r;

  scs_ram #(.WIDTH(16), .DEPTH(PROGRAM_WORDS)) u_prog (
    .clk   (clk),
    .we    (prog_we),
    .waddr (prog_waddr),
    .wdata (prog_wdata),
    .raddr (prog_raddr),
    .rdata (prog_rdata)
  );

  assign dat_we    = (clearing && (clr_addr <= CLR_D)) || (commit && op == OP_ST);
  assign dat_waddr = clearing ? clr_addr[DAW-1:0] : daddr;
  assign dat_wdata = clearing ? '0 : va;

  scs_ram #(.WIDTH(16), .DEPTH(DATA_WORDS)) u_data (
    .clk   (clk),
    .we    (dat_we),
    .waddr (dat_waddr),
    .wdata (dat_wdata),
    .raddr (daddr),
    .rdata (dat_rdata)
  );

  // Push writes at sp; pop clears the entry below sp after reading it.
  assign push_wr   = commit && (op == OP_PUSH);
  assign pop_wr    = commit && (op == OP_POP);
  assign stk_we    = (clearing && (clr_addr <= CLR_S)) || push_wr || pop_wr;
  assign stk_waddr = clearing ? clr_addr[SAW-1:0] : (push_wr ? sp : sp_dec);
  assign stk_wdata = push_wr ? (link ? pc_plus2 : va) : '0;

  scs_ram #(.WIDTH(16), .DEPTH(STACK_WORDS)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (sp_dec),
    .rdata (stk_rdata)
  );

  // Register file: two copies written together give two read ports (rA, rB).
  assign rf_we    = clearing || (commit && reg_wr);
  assign rf_waddr = clearing ? clr_addr[RAW-1:0] : ry;
  assign rf_wdata = clearing ? '0 : res;

  scs_ram #(.WIDTH(16), .DEPTH(REG_COUNT)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (prog_rdata[11:8]),
    .rdata (rfa_rdata)
  );

  scs_ram #(.WIDTH(16), .DEPTH(REG_COUNT)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (prog_rdata[7:4]),
    .rdata (rfb_rdata)
  );

  // --------------------------------------------------------------------------
  // Execute: result, flags, next pc and next sp from the held operands.
  // --------------------------------------------------------------------------
  always_comb begin
    take = 1'b0;
    priority if (ry[COND_GT]) begin
      take = (vb != '0) && !vb[SIGN_BIT];
    end else if (ry[COND_LT]) begin
      take = vb[SIGN_BIT];
    end else if (ry[COND_NZ]) begin
      take = (vb != '0);
    end else if (ry[COND_Z]) begin
      take = (vb == '0);
    end else begin
      // empty condition field never jumps
      take = 1'b0;
    end
  end

  always_comb begin
    res     = '0;
    reg_wr  = 1'b0;
    jumped  = 1'b0;
    pc_next = pc_plus1;
    sp_next = sp;
    unique case (op)
      OP_MOV: begin
        res = va; reg_wr = 1'b1;
      end
      OP_LDI: begin
        res = imm; reg_wr = 1'b1; pc_next = pc_plus2;
      end
      OP_ST: begin
        res = '0;
      end
      OP_LD: begin
        res = dat_rdata; reg_wr = 1'b1;
      end
      OP_OR: begin
        res = va | vb; reg_wr = 1'b1;
      end
      OP_NOT: begin
        res = ~va; reg_wr = 1'b1;
      end
      OP_AND: begin
        res = va & vb; reg_wr = 1'b1;
      end
      OP_XOR: begin
        res = va ^ vb; reg_wr = 1'b1;
      end
      OP_ADD: begin
        res = va + vb; reg_wr = 1'b1;
      end
      OP_SUB: begin
        res = va - vb; reg_wr = 1'b1;
      end
      OP_LNOT: begin
        res = (va == '0) ? 16'd1 : 16'd0; reg_wr = 1'b1;
      end
      OP_SHR: begin
        res = va >> 1; reg_wr = 1'b1;
      end
      OP_PUSH: begin
        sp_next = sp_inc;
      end
      OP_POP: begin
        sp_next = sp_dec;
        if (link) begin
          pc_next = entry; jumped = 1'b1;
        end else begin
          res = entry; reg_wr = 1'b1;
        end
      end
      OP_JMP: begin
        pc_next = va; jumped = 1'b1;
      end
      OP_JC: begin
        if (take) begin
          pc_next = va; jumped = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    wb_result.pc_after            = pc_next;
    wb_result.reg_written         = reg_wr;
    wb_result.reg_index           = reg_wr ? ry : '0;
    wb_result.reg_value           = reg_wr ? res : '0;
    wb_result.data_written        = (op == OP_ST);
    wb_result.data_address        = (op == OP_ST) ? 16'(daddr) : '0;
    wb_result.data_value          = (op == OP_ST) ? va : '0;
    wb_result.stack_pointer_after = 16'(sp_next);
    wb_result.jump_taken          = jumped;

    load_result                     = '0;
    load_result.pc_after            = pc;
    load_result.stack_pointer_after = 16'(sp);
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      pc       <= '0;
      sp       <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == CLR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_PW1;
          end
        end
        S_PW1: begin
          state <= S_PW2;
        end
        S_PW2: begin
          state <= is_load ? S_LOAD : S_DEC;
        end
        S_LOAD: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        S_DEC: begin
          state <= S_OPR;
        end
        S_OPR: begin
          state <= (op == OP_ST || op == OP_LD) ? S_DW1 : S_WB;
        end
        S_DW1: begin
          state <= S_DW2;
        end
        S_DW2: begin
          state <= (op == OP_LD) ? S_DRD : S_WB;
        end
        S_DRD: begin
          state <= S_WB;
        end
        S_WB: begin
          // hold until the output register can take the result
          if (slot_free) begin
            pc    <= pc_next;
            sp    <= sp_next;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath holding registers
  always_ff @(posedge clk) begin
    if (accept) begin
      is_load <= item.operation;
      lword   <= item.load_word;
    end
    if (state == S_PW2) begin
      paddr <= p_wrap_r;
    end
    if (state == S_DEC) begin
      instr <= prog_rdata;
    end
    if (state == S_OPR) begin
      va    <= rfa_rdata;
      vb    <= rfb_rdata;
      imm   <= prog_rdata;
      entry <= stk_rdata;
    end
    if (state == S_DW2) begin
      daddr <= d_wrap_r;
    end
  end

  // Output register: load a new result on commit, drop the old one when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (commit || (state == S_LOAD && slot_free)) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      result <= wb_result;
    end else if (state == S_LOAD && slot_free) begin
      result <= load_result;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_result_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == S_WB || $past(state) == S_LOAD))
    else $error("result appeared without a commit");

  a_prog_write_phase: assert property (@(posedge clk) disable iff (rst)
    prog_we |-> (state == S_CLEAR || state == S_LOAD))
    else $error("program memory written outside clear or program write");

  a_sp_on_commit: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(sp)) |-> $past(commit))
    else $error("stack pointer moved without a commit");

  a_data_write_store: assert property (@(posedge clk) disable iff (rst)
    (dat_we && state != S_CLEAR) |-> (op == OP_ST && state == S_WB))
    else $error("data memory written by a non-store");

  a_no_accept_when_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_PW1))
    else $error("accepted request did not start the sequence");

endmodule

@@ bench/sixteen_bit_cpu_step_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sixteen_bit_cpu_step_tb: self-checking bench of the 16-bit processor step
// A directed program walks every opcode, the stack wrap and the program
// counter wrap. Random requests then write instructions at the predicted pc
// and execute them. Results are checked against a model or fixed values.
// ----------------------------------------------------------------------------
module sixteen_bit_cpu_step_tb;
  import scs_pkg::*;

  localparam int PROGRAM_WORDS = 65536;
  localparam int DATA_WORDS    = 65536;
  localparam int STACK_WORDS   = 65536;

  localparam int TOTAL_ITEMS = 1900;   // stimulus stops after this many requests
  localparam int TAIL_ITEMS  = 200;    // final stretch runs with no idling
  localparam int DRAIN_CYCLES = 16;    // longer than the slowest instruction
  // Bound for the clearing pass plus all ~1900 requests
  localparam int CYCLE_LIMIT = 400000;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_ready;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  // Behavioral copy of the processor state; all memories start at zero
  bit [15:0] prog_mem  [PROGRAM_WORDS];
  bit [15:0] data_mem  [DATA_WORDS];
  bit [15:0] stack_mem [STACK_WORDS];
  bit [15:0] regs      [REG_COUNT];
  bit [15:0] pc_q;
  int        sp_q;

  // Results owed by the block, oldest first
  result_t pending_steps [$];

  // Directed program, one row per request
  item_t   plan_req   [$];
  bit      plan_typed [$];
  result_t plan_want  [$];

  int   requests_sent = 0;
  int   results_seen  = 0;
  int   mismatches    = 0;
  int   cycle_count   = 0;
  int   stall_left    = 0;
  logic quiet;

  assign quiet = requests_sent >= TOTAL_ITEMS - TAIL_ITEMS;

  sixteen_bit_cpu_step #(
    .PROGRAM_WORDS(PROGRAM_WORDS),
    .DATA_WORDS   (DATA_WORDS),
    .STACK_WORDS  (STACK_WORDS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  always #10 clk = ~clk;

  // Watchdog: end the run if the block stops making progress
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [15:0] encode_instr(logic [3:0] opc, logic [3:0] ra,
                                               logic [3:0] rb, logic [3:0] ry);
    return {opc, ra, rb, ry};
  endfunction

  function automatic item_t load_request(logic [15:0] addr, logic [15:0] word);
    item_t req;
    req.operation    = 1'b1;
    req.load_address = addr;
    req.load_word    = word;
    return req;
  endfunction

  // Load fields of an execute request are ignored: fill them with noise
  function automatic item_t exec_request();
    item_t req;
    req.operation    = 1'b0;
    req.load_address = 16'($urandom);
    req.load_word    = 16'($urandom);
    return req;
  endfunction

  // Result of a step that touches nothing: pc and sp reported, flags clear
  function automatic result_t quiet_result(logic [15:0] pc, logic [15:0] sp);
    result_t res;
    res = '0;
    res.pc_after            = pc;
    res.stack_pointer_after = sp;
    return res;
  endfunction

  // Immediates lean on the values that matter for signed tests and wrap
  function automatic logic [15:0] pick_immediate();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'h7fff;
      2:       return 16'h8000;
      3:       return 16'hffff;
      4:       return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  // Advance the model by one request and return the result it owes
  task automatic execute_step(input item_t req, output result_t res);
    logic [15:0] word, va, vb, nxt, rv, entry;
    logic [3:0]  opc, ra, rb, ry;
    logic        link, take;
    int          paddr;
    res = '0;
    if (req.operation) begin
      prog_mem[req.load_address % PROGRAM_WORDS] = req.load_word;
    end else begin
      paddr = pc_q % PROGRAM_WORDS;
      word  = prog_mem[paddr];
      opc   = word[15:12];
      ra    = word[11:8];
      rb    = word[7:4];
      ry    = word[3:0];
      link  = word[LINK_BIT];
      va    = regs[ra];
      vb    = regs[rb];
      nxt   = pc_q + 16'd1;
      rv    = '0;
      take  = 1'b0;
      case (opc)
        OP_MOV: begin
          rv = va;
          res.reg_written = 1'b1;
        end
        OP_LDI: begin
          // immediate sits in the next word, wrapping at the end of memory
          rv  = prog_mem[(paddr + 1) % PROGRAM_WORDS];
          nxt = pc_q + 16'd2;
          res.reg_written = 1'b1;
        end
        OP_ST: begin
          res.data_written = 1'b1;
          res.data_address = 16'(vb % DATA_WORDS);
          res.data_value   = va;
          data_mem[vb % DATA_WORDS] = va;
        end
        OP_LD: begin
          rv = data_mem[va % DATA_WORDS];
          res.reg_written = 1'b1;
        end
        OP_OR:   begin rv = va | vb;          res.reg_written = 1'b1; end
        OP_NOT:  begin rv = ~va;              res.reg_written = 1'b1; end
        OP_AND:  begin rv = va & vb;          res.reg_written = 1'b1; end
        OP_XOR:  begin rv = va ^ vb;          res.reg_written = 1'b1; end
        OP_ADD:  begin rv = va + vb;          res.reg_written = 1'b1; end
        OP_SUB:  begin rv = va - vb;          res.reg_written = 1'b1; end
        OP_LNOT: begin rv = (va == 0) ? 16'd1 : 16'd0; res.reg_written = 1'b1; end
        OP_SHR:  begin rv = va >> 1;          res.reg_written = 1'b1; end
        OP_PUSH: begin
          stack_mem[sp_q] = link ? pc_q + 16'd2 : va;
          sp_q = (sp_q + 1) % STACK_WORDS;
        end
        OP_POP: begin
          // decrement first, read the entry, then clear it
          sp_q  = (sp_q + STACK_WORDS - 1) % STACK_WORDS;
          entry = stack_mem[sp_q];
          stack_mem[sp_q] = '0;
          if (link) begin
            nxt = entry;
            res.jump_taken = 1'b1;
          end else begin
            rv = entry;
            res.reg_written = 1'b1;
          end
        end
        OP_JMP: begin
          nxt = va;
          res.jump_taken = 1'b1;
        end
        OP_JC: begin
          if (ry[COND_GT])      take = (vb != 0) && !vb[SIGN_BIT];
          else if (ry[COND_LT]) take = vb[SIGN_BIT];
          else if (ry[COND_NZ]) take = vb != 0;
          else if (ry[COND_Z])  take = vb == 0;
          if (take) begin
            nxt = va;
            res.jump_taken = 1'b1;
          end
        end
      endcase
      if (res.reg_written) begin
        regs[ry]      = rv;
        res.reg_index = ry;
        res.reg_value = rv;
      end
      pc_q = nxt;
    end
    res.pc_after            = pc_q;
    res.stack_pointer_after = 16'(sp_q);
  endtask

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    $display("mismatch at result %0d: %s got %h expected %h",
             results_seen, field, got, want);
  endtask

  task automatic check_result(input result_t got, input result_t want);
    if (got.pc_after != want.pc_after)
      report_mismatch("pc_after", got.pc_after, want.pc_after);
    if (got.reg_written != want.reg_written)
      report_mismatch("reg_written", 16'(got.reg_written), 16'(want.reg_written));
    if (got.reg_index != want.reg_index)
      report_mismatch("reg_index", 16'(got.reg_index), 16'(want.reg_index));
    if (got.reg_value != want.reg_value)
      report_mismatch("reg_value", got.reg_value, want.reg_value);
    if (got.data_written != want.data_written)
      report_mismatch("data_written", 16'(got.data_written), 16'(want.data_written));
    if (got.data_address != want.data_address)
      report_mismatch("data_address", got.data_address, want.data_address);
    if (got.data_value != want.data_value)
      report_mismatch("data_value", got.data_value, want.data_value);
    if (got.stack_pointer_after != want.stack_pointer_after)
      report_mismatch("stack_pointer_after", got.stack_pointer_after,
                      want.stack_pointer_after);
    if (got.jump_taken != want.jump_taken)
      report_mismatch("jump_taken", 16'(got.jump_taken), 16'(want.jump_taken));
  endtask

  // Drop valid for a short random burst, except in the final stretch
  task automatic pause_sender();
    if (!quiet && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Present one request, hold it until accepted, then log what it owes.
  // Called at a rising edge; returns at the edge of acceptance.
  task automatic send_request(input item_t req, input bit typed, input result_t want);
    result_t predicted;
    pause_sender();
    item       <= req;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    execute_step(req, predicted);
    pending_steps.push_back(typed ? want : predicted);
    requests_sent++;
  endtask

  task automatic add_row(input item_t req, input bit typed, input result_t want);
    plan_req.push_back(req);
    plan_typed.push_back(typed);
    plan_want.push_back(want);
  endtask

  // Result side: random stall bursts on ready, and check each accepted result
  always @(posedge clk) begin
    if (result_valid && result_ready) begin
      if (pending_steps.size() == 0) begin
        report_mismatch("unexpected result, pc_after", result.pc_after, 16'h0000);
      end else begin
        check_result(result, pending_steps.pop_front());
      end
      results_seen++;
    end
    if (rst || quiet) begin
      result_ready <= 1'b1;
    end else if (stall_left > 0) begin
      result_ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      result_ready <= 1'b0;
      stall_left   <= $urandom_range(0, 2);
    end else begin
      result_ready <= 1'b1;
    end
  end

  initial begin
    result_t     mov_zero;
    result_t     untouched;
    logic [15:0] word;
    bit          held_once;
    int          pick;

    held_once = 1'b0;

    // Directed program. Empty memory decodes as a move r0 <- r0, so the
    // first execute is known outright; every load that follows reports the
    // pc of 1 it leaves unchanged.
    mov_zero = quiet_result(16'd1, 16'd0);
    mov_zero.reg_written = 1'b1;
    untouched = quiet_result(16'd1, 16'd0);
    add_row(exec_request(), 1'b1, mov_zero);
    add_row(load_request(16'd1,  encode_instr(OP_LDI, 4'd0, 4'd0, 4'd1)), 1'b1, untouched);
    add_row(load_request(16'd2,  16'hffff), 1'b1, untouched);   // immediate for r1
    add_row(load_request(16'd3,  encode_instr(OP_ADD,  4'd1, 4'd1, 4'd2)), 1'b1, untouched);
    add_row(load_request(16'd4,  encode_instr(OP_SUB,  4'd0, 4'd1, 4'd3)), 1'b1, untouched);
    add_row(load_request(16'd5,  encode_instr(OP_OR,   4'd1, 4'd3, 4'd4)), 1'b1, untouched);
    add_row(load_request(16'd6,  encode_instr(OP_AND,  4'd2, 4'd3, 4'd5)), 1'b1, untouched);
    add_row(load_request(16'd7,  encode_instr(OP_XOR,  4'd1, 4'd2, 4'd6)), 1'b1, untouched);
    add_row(load_request(16'd8,  encode_instr(OP_NOT,  4'd3, 4'd0, 4'd7)), 1'b1, untouched);
    add_row(load_request(16'd9,  encode_instr(OP_LNOT, 4'd5, 4'd0, 4'd8)), 1'b1, untouched);
    add_row(load_request(16'd10, encode_instr(OP_SHR,  4'd1, 4'd0, 4'd9)), 1'b1, untouched);
    // store to the top data address, then read it back
    add_row(load_request(16'd11, encode_instr(OP_ST,   4'd2, 4'd1, 4'd0)), 1'b1, untouched);
    add_row(load_request(16'd12, encode_instr(OP_LD,   4'd1, 4'd0, 4'd10)), 1'b1, untouched);
    // rB of 8 sets the link bit: push the return address, pop it into pc
    add_row(load_request(16'd13, encode_instr(OP_PUSH, 4'd0, 4'd8, 4'd0)), 1'b1, untouched);
    add_row(load_request(16'd14, encode_instr(OP_POP,  4'd0, 4'd8, 4'd0)), 1'b1, untouched);
    // pop from an empty stack wraps sp down to the top entry
    add_row(load_request(16'd15, encode_instr(OP_POP,  4'd0, 4'd0, 4'd11)), 1'b1, untouched);
    // greater-than test on 0x7fff is taken toward 0xfffe
    add_row(load_request(16'd16, encode_instr(OP_JC,   4'd2, 4'd9, 4'b1000)), 1'b1, untouched);
    add_row(load_request(16'hfffe, encode_instr(OP_JMP, 4'd1, 4'd0, 4'd0)), 1'b1, untouched);
    // load immediate at the last word fetches from word 0 and wraps pc
    add_row(load_request(16'hffff, encode_instr(OP_LDI, 4'd0, 4'd0, 4'd13)), 1'b1, untouched);
    repeat (17) add_row(exec_request(), 1'b0, '0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // The block clears its memories after reset; the first request waits
    // on ready through that pass.
    foreach (plan_req[i]) send_request(plan_req[i], plan_typed[i], plan_want[i]);

    while (requests_sent < TOTAL_ITEMS) begin
      // Once, midway: hold off until the block has returned everything
      if (!held_once && requests_sent >= TOTAL_ITEMS / 2) begin
        held_once = 1'b1;
        item_valid <= 1'b0;
        do @(posedge clk); while (pending_steps.size() != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // Plant a random instruction at the predicted pc, then run it
        word = 16'($urandom);
        if ($urandom_range(0, 3) == 0) word[15:12] = OP_LDI;
        send_request(load_request(pc_q, word), 1'b0, '0);
        if (word[15:12] == OP_LDI)
          send_request(load_request(pc_q + 16'd1, pick_immediate()), 1'b0, '0);
        send_request(exec_request(), 1'b0, '0);
      end else if (pick < 85) begin
        // Run whatever memory holds at pc
        send_request(exec_request(), 1'b0, '0);
      end else begin
        // Stray program write anywhere
        send_request(load_request(16'($urandom), 16'($urandom)), 1'b0, '0);
      end
    end

    item_valid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
